@@ design/smseq_pkg.sv @@
// ----------------------------------------------------------------------------
// smseq_pkg: shared types, codes and CRC helpers
// Holds the transaction types, link codes, sensor command bytes and the CRC-8
// (poly 0x31) step functions used by the measurement sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package smseq_pkg;

  // Tick counter width default and configuration register geometry
  localparam int TICK_W_DEFAULT = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_REST_TICKS    = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CONVERT_LIMIT = 1'd1;

  localparam logic [15:0] REST_TICKS_RESET    = 16'd5;
  localparam logic [15:0] CONVERT_LIMIT_RESET = 16'd500;

  // Link status codes
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;

  // Link command codes
  localparam logic [2:0] LC_NONE      = 3'd0;
  localparam logic [2:0] LC_INIT      = 3'd1;
  localparam logic [2:0] LC_RESET     = 3'd2;
  localparam logic [2:0] LC_SEND      = 3'd3;
  localparam logic [2:0] LC_READ_ACK  = 3'd4;
  localparam logic [2:0] LC_READ_NACK = 3'd5;

  // Sensor measurement commands
  localparam logic [7:0] CMD_TEMP = 8'h03;
  localparam logic [7:0] CMD_HUM  = 8'h05;

  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [3:0] PHASE_REST = 4'd0;
  localparam logic [3:0] PHASE_LAST = 4'd11;

  typedef struct packed {
    logic [1:0] link_status;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  link_command;
    logic [7:0]  command_byte;
    logic [15:0] temperature_raw;
    logic [15:0] humidity_raw;
    logic        sample_ready;
    logic        crc_fail;
    logic [3:0]  phase_now;
  } out_item_t;

  typedef struct packed {
    logic [15:0] rest_ticks;
    logic [15:0] convert_limit_ticks;
  } cfg_regs_t;

  // Shift one byte, MSB first, through the CRC-8 register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = data[i] ^ crc[7];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // CRC state after the command byte, from a zero start
  localparam logic [7:0] CRC_AFTER_TEMP = crc8_byte(8'h00, CMD_TEMP);
  localparam logic [7:0] CRC_AFTER_HUM  = crc8_byte(8'h00, CMD_HUM);

endpackage

`default_nettype wire

@@ design/smseq_if.sv @@
// ----------------------------------------------------------------------------
// smseq_in_if / smseq_out_if: valid-ready channels
// Carry one tick item into the sequencer and one result item out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface smseq_in_if;
  import smseq_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface smseq_out_if;
  import smseq_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/sensor_measure_sequencer.sv @@
// ----------------------------------------------------------------------------
// sensor_measure_sequencer: temperature / humidity poll sequencer
// Steps a byte-link measurement sequence once per tick transaction and
// returns the link command, raw samples and status for every tick.
// ----------------------------------------------------------------------------
`default_nettype none

// Each input transaction is one tick: the byte link's status and its last
// received byte. Every tick yields exactly one result transaction carrying the
// link command to issue, the command byte, the latest raw temperature and
// humidity words, the sample-ready and CRC-fail flags and the phase reached.
// On each tick the sequencer state updates in the accepting cycle
// and the result lands in the output register, so one transaction is taken
// every cycle while the result side keeps up (in_ch.ready stays high whenever
// the output register is empty or being drained). The CRC-8 check is spread
// over the read phases one byte at a time, so each cycle shifts at most eight
// bits. cfg_index 0 writes rest_ticks, 1 writes convert_limit_ticks; write
// them only while no tick is in flight.

module sensor_measure_sequencer #(
  parameter int TICK_COUNTER_WIDTH = smseq_pkg::TICK_W_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  smseq_in_if.sink                               in_ch,
  smseq_out_if.source                            out_ch,
  input  wire logic                              cfg_we,
  input  wire logic [smseq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [smseq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import smseq_pkg::*;

  cfg_regs_t cfg_r;
  out_item_t result;
  out_item_t out_data_r;
  logic      out_valid_r;
  logic      accept;

  // Take a new tick whenever the output register is free or being drained
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rest_ticks          <= REST_TICKS_RESET;
      cfg_r.convert_limit_ticks <= CONVERT_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_REST_TICKS:    cfg_r.rest_ticks          <= cfg_data;
        CFG_CONVERT_LIMIT: cfg_r.convert_limit_ticks <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Sequencer: advance only on an accepted tick
  smseq_core #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .item    (in_ch.data),
    .cfg     (cfg_r),
    .result  (result)
  );

  // Output register: load on accept, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  // Every accepted tick produces a result in the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_ch.valid)
    else $error("accepted tick produced no result");

  // A result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !accept)
    else $error("pending result overwritten");

  // A completed pair always lands back in rest, and never with a CRC failure
  a_ready_in_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.sample_ready) |->
      (out_data_r.phase_now == PHASE_REST && !out_data_r.crc_fail))
    else $error("sample ready outside rest or with CRC failure");

  // Phase never leaves the defined range
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.phase_now <= PHASE_LAST))
    else $error("phase out of range");

endmodule

`default_nettype wire

@@ design/smseq_core.sv @@
// ----------------------------------------------------------------------------
// smseq_core: measurement phase sequencer
// Holds phase, tick age, raw stores and running CRC; steps once per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module smseq_core #(
  parameter int TICK_COUNTER_WIDTH = smseq_pkg::TICK_W_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 advance,
  input  wire smseq_pkg::in_item_t  item,
  input  wire smseq_pkg::cfg_regs_t cfg,
  output smseq_pkg::out_item_t      result
);
  import smseq_pkg::*;

  localparam int CMP_W = (TICK_COUNTER_WIDTH > CFG_DATA_W) ? TICK_COUNTER_WIDTH : CFG_DATA_W;

  typedef enum logic [3:0] {
    PH_REST    = 4'd0,
    PH_T_INIT  = 4'd1,
    PH_T_CMD   = 4'd2,
    PH_T_HIGH  = 4'd3,
    PH_T_LOW   = 4'd4,
    PH_T_CRC   = 4'd5,
    PH_H_INIT  = 4'd6,
    PH_H_CMD   = 4'd7,
    PH_H_HIGH  = 4'd8,
    PH_H_LOW   = 4'd9,
    PH_H_CRC   = 4'd10,
    PH_CLEAR   = 4'd11
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [TICK_COUNTER_WIDTH-1:0] elapsed_r, elapsed_nxt;
  logic [15:0]                   temp_r, temp_nxt;
  logic [15:0]                   hum_r, hum_nxt;
  logic [7:0]                    crc_r, crc_nxt;

  logic       idle, err, mark;
  logic       is_temp;
  logic [7:0] code;
  logic [7:0] crc_start;
  logic [7:0] store_cur;
  logic       rest_done, convert_done;
  logic [2:0] cmd;
  logic [7:0] cbyte;
  logic       ready, fail;

  assign idle    = (item.link_status == ST_IDLE);
  assign err     = (item.link_status != ST_IDLE) && (item.link_status != ST_BUSY);
  assign is_temp = (phase_r <= PH_T_CRC);
  assign code      = is_temp ? CMD_TEMP : CMD_HUM;
  assign crc_start = is_temp ? CRC_AFTER_TEMP : CRC_AFTER_HUM;
  assign store_cur = is_temp ? temp_r[7:0] : hum_r[7:0];

  assign rest_done    = CMP_W'(cfg.rest_ticks) <= CMP_W'(elapsed_r);
  assign convert_done = CMP_W'(cfg.convert_limit_ticks) <= CMP_W'(elapsed_r);

  always_comb begin
    phase_nxt = phase_r;
    temp_nxt  = temp_r;
    hum_nxt   = hum_r;
    crc_nxt   = crc_r;
    mark      = 1'b0;
    cmd       = LC_NONE;
    cbyte     = 8'h00;
    ready     = 1'b0;
    fail      = 1'b0;
    case (phase_r)
      PH_REST: begin
        if (rest_done) begin
          if (!idle) begin
            cmd       = LC_RESET;
            phase_nxt = PH_CLEAR;
          end else begin
            cmd       = LC_INIT;
            phase_nxt = PH_T_INIT;
          end
        end
      end
      PH_T_INIT, PH_H_INIT: begin
        if (idle) begin
          cmd       = LC_SEND;
          cbyte     = code;
          mark      = 1'b1;
          phase_nxt = is_temp ? PH_T_CMD : PH_H_CMD;
        end else if (err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end
      end
      PH_T_CMD, PH_H_CMD: begin
        if (idle) begin
          cmd       = LC_READ_ACK;
          phase_nxt = is_temp ? PH_T_HIGH : PH_H_HIGH;
        end else if (err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end else if (convert_done) begin
          cmd       = LC_RESET;
          phase_nxt = PH_CLEAR;
        end
      end
      PH_T_HIGH, PH_H_HIGH: begin
        if (idle) begin
          // Latch the high byte and fold it into the running CRC
          if (is_temp) begin
            temp_nxt = {item.rx_byte, 8'h00};
          end else begin
            hum_nxt = {item.rx_byte, 8'h00};
          end
          crc_nxt   = crc8_byte(crc_start, item.rx_byte);
          cmd       = LC_READ_ACK;
          phase_nxt = is_temp ? PH_T_LOW : PH_H_LOW;
        end else if (err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end
      end
      PH_T_LOW, PH_H_LOW: begin
        if (idle) begin
          if (is_temp) begin
            temp_nxt = {temp_r[15:8], temp_r[7:0] | item.rx_byte};
          end else begin
            hum_nxt = {hum_r[15:8], hum_r[7:0] | item.rx_byte};
          end
          crc_nxt   = crc8_byte(crc_r, store_cur | item.rx_byte);
          cmd       = LC_READ_NACK;
          phase_nxt = is_temp ? PH_T_CRC : PH_H_CRC;
        end else if (err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end
      end
      PH_T_CRC, PH_H_CRC: begin
        if (idle) begin
          if (bit_rev8(crc_r) == item.rx_byte) begin
            mark = 1'b1;
            if (is_temp) begin
              cmd       = LC_INIT;
              phase_nxt = PH_H_INIT;
            end else begin
              ready     = 1'b1;
              phase_nxt = PH_REST;
            end
          end else begin
            fail      = 1'b1;
            cmd       = LC_RESET;
            phase_nxt = PH_CLEAR;
          end
        end else if (err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end
      end
      PH_CLEAR: begin
        if (idle || err) begin
          mark      = 1'b1;
          phase_nxt = PH_REST;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase
  end

  always_comb begin
    if (mark) begin
      elapsed_nxt = TICK_COUNTER_WIDTH'(1);
    end else if (elapsed_r != {TICK_COUNTER_WIDTH{1'b1}}) begin
      elapsed_nxt = elapsed_r + TICK_COUNTER_WIDTH'(1);
    end else begin
      elapsed_nxt = elapsed_r;
    end
  end

  always_comb begin
    result.link_command    = cmd;
    result.command_byte    = cbyte;
    result.temperature_raw = temp_nxt;
    result.humidity_raw    = hum_nxt;
    result.sample_ready    = ready;
    result.crc_fail        = fail;
    result.phase_now       = phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_REST;
      elapsed_r <= '0;
      temp_r    <= '0;
      hum_r     <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      temp_r    <= temp_nxt;
      hum_r     <= hum_nxt;
    end
  end

  // Running CRC is read when the low byte is folded in and checked in a checksum phase
  always_ff @(posedge clk) begin
    if (advance) begin
      crc_r <= crc_nxt;
    end
  end

endmodule

`default_nettype wire
